/* sv/ts_packetizer_core_macros.svh */
// Assertion macros used by the packetizer top level.
`ifndef TS_PACKETIZER_CORE_MACROS_SVH
`define TS_PACKETIZER_CORE_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define TSP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define TSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/tsp_pkg.sv */
// Types, constants and header byte function for the transport stream packetizer.
`timescale 1ns / 1ps
`default_nettype none
package tsp_pkg;

   localparam int unsigned PES_LENGTH_PORT_W = 24;
   localparam int unsigned QUEUE_DEPTH       = 2;

   localparam logic [7:0] SYNC_BYTE     = 8'h47;
   localparam logic [7:0] HDR_BYTES     = 8'd4;
   localparam logic [7:0] PAYLOAD_FULL  = 8'd184;
   localparam logic [7:0] PAYLOAD_PCR   = 8'd176;
   localparam logic [7:0] PKT_LAST_POS  = 8'd187;
   localparam logic [7:0] PCR_FLAG_BYTE = 8'h10;
   localparam logic [7:0] NO_FLAG_BYTE  = 8'h00;
   localparam logic [6:0] PCR_EXT_FILL  = 7'h7E;
   localparam logic [7:0] PCR_EXT_LOW   = 8'h00;
   localparam logic [7:0] STUFF_BYTE    = 8'hFF;

   // One accepted PES byte, with the header fields it needs if it opens a packet.
   typedef struct packed {
      logic [7:0]  data;
      logic        hdr;
      logic        first;
      logic        pcr;
      logic [32:0] pcr_base;
      logic [12:0] pid;
      logic [3:0]  cc;
      logic [7:0]  adapt;
   } tsp_entry_type;

   typedef enum logic [0:0] {
      BK_IDLE,
      BK_HDR
   } tsp_back_state_type;

   // Byte at packet position p of a packet opened by entry e; the data byte
   // sits right after the header and adaptation field.
   function automatic logic [7:0] hdr_byte(input logic [7:0] p, input tsp_entry_type e);
      logic [7:0] hlen;
      logic [7:0] b;
      hlen = e.adapt + HDR_BYTES;
      if (p > hlen) begin
         b = 8'h00;
      end else if (p == hlen) begin
         b = e.data;
      end else begin
         case (p)
            8'd0:    b = SYNC_BYTE;
            8'd1:    b = {1'b0, e.first, 1'b0, e.pid[12:8]};
            8'd2:    b = e.pid[7:0];
            8'd3:    b = {2'b00, e.adapt != 8'd0, 1'b1, e.cc};
            8'd4:    b = e.adapt - 8'd1;
            8'd5:    b = e.pcr ? PCR_FLAG_BYTE : NO_FLAG_BYTE;
            8'd6:    b = e.pcr ? e.pcr_base[32:25] : STUFF_BYTE;
            8'd7:    b = e.pcr ? e.pcr_base[24:17] : STUFF_BYTE;
            8'd8:    b = e.pcr ? e.pcr_base[16:9] : STUFF_BYTE;
            8'd9:    b = e.pcr ? e.pcr_base[8:1] : STUFF_BYTE;
            8'd10:   b = e.pcr ? {e.pcr_base[0], PCR_EXT_FILL} : STUFF_BYTE;
            8'd11:   b = e.pcr ? PCR_EXT_LOW : STUFF_BYTE;
            default: b = STUFF_BYTE;
         endcase
      end
      return b;
   endfunction

endpackage
`default_nettype wire

/* sv/tsp_front.sv */
// Front end: accepts PES bytes, tracks PES and packet boundaries, builds header fields.
`timescale 1ns / 1ps
`default_nettype none
module tsp_front #(
   parameter int unsigned STREAM_COUNT    = 8,
   parameter int unsigned PES_LENGTH_BITS = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  req_pes_start,
   input  wire logic [23:0]           req_pes_length,
   input  wire logic                  req_with_pcr,
   input  wire logic [32:0]           req_pcr_base,
   input  wire logic [2:0]            req_stream_index,
   input  wire logic [12:0]           req_pid,
   input  wire logic                  q_full,
   output logic                       q_push,
   output tsp_pkg::tsp_entry_type     q_entry
);

   localparam int unsigned LEN_W  = (PES_LENGTH_BITS < tsp_pkg::PES_LENGTH_PORT_W) ?
                                    PES_LENGTH_BITS : tsp_pkg::PES_LENGTH_PORT_W;
   localparam int unsigned SIDX_W = $clog2(STREAM_COUNT);

   function automatic logic [SIDX_W-1:0] stream_mod(input logic [2:0] v);
      logic [4:0] r;
      r = {2'b00, v};
      for (int k = 0; k < 8; k++) begin
         if (r >= 5'(STREAM_COUNT)) begin
            r = r - 5'(STREAM_COUNT);
         end
      end
      return SIDX_W'(r);
   endfunction

   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [7:0]        left_ff, left_in;
   logic [12:0]       pid_ff, pid_in;
   logic [SIDX_W-1:0] stream_ff, stream_in;
   logic [3:0]        cc_ff [STREAM_COUNT];
   logic [3:0]        cc_in [STREAM_COUNT];

   logic              accept;
   logic              open;
   logic              takes;
   logic [LEN_W-1:0]  len_masked;
   logic [LEN_W-1:0]  cur_rem;
   logic [SIDX_W-1:0] cur_stream;
   logic [12:0]       cur_pid;
   logic              need_hdr;
   logic              carry_pcr;
   logic [7:0]        space;
   logic [7:0]        take;
   logic [3:0]        cc_cur;

   assign req_stall  = q_full;
   assign accept     = req_valid && !q_full;
   assign open       = rem_ff != '0;
   // Drop a byte that arrives with no PES open and no start mark.
   assign takes      = accept && (open || req_pes_start);
   assign len_masked = req_pes_length[LEN_W-1:0];
   assign cur_rem    = open ? rem_ff : ((len_masked == '0) ? LEN_W'(1) : len_masked);
   assign cur_stream = open ? stream_ff : stream_mod(req_stream_index);
   assign cur_pid    = open ? pid_ff : req_pid;
   assign need_hdr   = !open || (left_ff == 8'd0);
   assign carry_pcr  = !open && req_with_pcr;
   assign space      = carry_pcr ? tsp_pkg::PAYLOAD_PCR : tsp_pkg::PAYLOAD_FULL;
   assign take       = (cur_rem < LEN_W'(space)) ? cur_rem[7:0] : space;
   assign cc_cur     = cc_ff[cur_stream];

   assign q_push           = takes;
   assign q_entry.data     = req_data_byte;
   assign q_entry.hdr      = need_hdr;
   assign q_entry.first    = !open;
   assign q_entry.pcr      = carry_pcr;
   assign q_entry.pcr_base = req_pcr_base;
   assign q_entry.pid      = cur_pid;
   assign q_entry.cc       = cc_cur;
   assign q_entry.adapt    = tsp_pkg::PAYLOAD_FULL - take;

   always_comb begin
      rem_in    = rem_ff;
      left_in   = left_ff;
      pid_in    = pid_ff;
      stream_in = stream_ff;
      cc_in     = cc_ff;
      if (takes) begin
         rem_in    = cur_rem - LEN_W'(1);
         pid_in    = cur_pid;
         stream_in = cur_stream;
         if (need_hdr) begin
            left_in             = take - 8'd1;
            cc_in[cur_stream]   = cc_cur + 4'd1;
         end else begin
            left_in = left_ff - 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff    <= '0;
         left_ff   <= '0;
         pid_ff    <= '0;
         stream_ff <= '0;
         cc_ff     <= '{default: '0};
      end else begin
         rem_ff    <= rem_in;
         left_ff   <= left_in;
         pid_ff    <= pid_in;
         stream_ff <= stream_in;
         cc_ff     <= cc_in;
      end
   end

endmodule
`default_nettype wire

/* sv/tsp_queue.sv */
// Short queue of classified bytes between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module tsp_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  tsp_pkg::tsp_entry_type      push_entry,
   output logic                        full,
   input  wire logic                   pop,
   output logic                        head_valid,
   output tsp_pkg::tsp_entry_type      head
);

   localparam int unsigned DEPTH = tsp_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   tsp_pkg::tsp_entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

/* sv/tsp_back.sv */
// Back end: emits header words, packs payload bytes into words, drives the output register.
`timescale 1ns / 1ps
`default_nettype none
module tsp_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   head_valid,
   input  tsp_pkg::tsp_entry_type      head,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [31:0]                 rsp_ts_word,
   output logic                        rsp_packet_first_word,
   output logic                        rsp_packet_last_word,
   output logic                        rsp_last
);

   tsp_pkg::tsp_back_state_type state_ff, state_in;
   logic [7:0]       pos_ff, pos_in;
   logic [2:0][7:0]  part_ff, part_in;
   logic             out_valid_ff, out_valid_in;
   logic [31:0]      out_word_ff, out_word_in;
   logic             out_first_ff, out_first_in;
   logic             out_plast_ff, out_plast_in;
   logic             out_last_ff, out_last_in;

   logic             out_free;
   logic             load;
   logic [31:0]      new_word;
   logic             new_first;
   logic             new_plast;
   logic             new_last;
   logic [7:0]       hdr_len;
   logic [7:0]       end3;
   logic [31:0]      hdr_word;
   logic             hdr_full;
   logic             hdr_final;
   logic             hdr_lastw;
   logic [1:0]       slot;
   logic             at_pkt_end;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign hdr_len    = head.adapt + tsp_pkg::HDR_BYTES;
   assign end3       = pos_ff + 8'd3;
   assign hdr_full   = end3 <= hdr_len;
   assign hdr_final  = end3 >= hdr_len;
   // The next word would run past the data byte, so this one ends the step.
   assign hdr_lastw  = (pos_ff + 8'd7) > hdr_len;
   assign slot       = pos_ff[1:0];
   assign at_pkt_end = pos_ff == tsp_pkg::PKT_LAST_POS;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         hdr_word[31 - 8*i -: 8] = tsp_pkg::hdr_byte(pos_ff + 8'(i), head);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tsp_pkg::BK_IDLE: begin
            if (head_valid && head.hdr) begin
               state_in = tsp_pkg::BK_HDR;
            end
         end
         tsp_pkg::BK_HDR: begin
            if (hdr_final && (!hdr_full || out_free)) begin
               state_in = tsp_pkg::BK_IDLE;
            end
         end
         default: state_in = tsp_pkg::BK_IDLE;
      endcase
   end

   // Outputs and datapath
   always_comb begin
      pop       = 1'b0;
      load      = 1'b0;
      new_word  = '0;
      new_first = 1'b0;
      new_plast = 1'b0;
      new_last  = 1'b0;
      pos_in    = pos_ff;
      part_in   = part_ff;
      case (state_ff)
         tsp_pkg::BK_IDLE: begin
            if (head_valid && !head.hdr) begin
               if (slot == 2'd3) begin
                  if (out_free) begin
                     load      = 1'b1;
                     new_word  = {part_ff[0], part_ff[1], part_ff[2], head.data};
                     new_first = pos_ff == 8'd3;
                     new_plast = at_pkt_end;
                     new_last  = 1'b1;
                     pop       = 1'b1;
                     pos_in    = at_pkt_end ? 8'd0 : pos_ff + 8'd1;
                  end
               end else begin
                  part_in[slot] = head.data;
                  pop           = 1'b1;
                  pos_in        = pos_ff + 8'd1;
               end
            end
         end
         tsp_pkg::BK_HDR: begin
            if (hdr_full) begin
               if (out_free) begin
                  load      = 1'b1;
                  new_word  = hdr_word;
                  new_first = pos_ff == 8'd0;
                  new_plast = end3 == tsp_pkg::PKT_LAST_POS;
                  new_last  = hdr_lastw;
                  if (hdr_final) begin
                     pop    = 1'b1;
                     pos_in = (end3 == tsp_pkg::PKT_LAST_POS) ? 8'd0 : end3 + 8'd1;
                  end else begin
                     pos_in = pos_ff + 8'd4;
                  end
               end
            end else begin
               // Hold the bytes up to the data byte for the next payload bytes.
               part_in[0] = hdr_word[31:24];
               part_in[1] = hdr_word[23:16];
               part_in[2] = hdr_word[15:8];
               pop        = 1'b1;
               pos_in     = hdr_len + 8'd1;
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   assign out_valid_in = load || (out_valid_ff && rsp_stall);
   assign out_word_in  = load ? new_word : out_word_ff;
   assign out_first_in = load ? new_first : out_first_ff;
   assign out_plast_in = load ? new_plast : out_plast_ff;
   assign out_last_in  = load ? new_last : out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsp_pkg::BK_IDLE;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      part_ff      <= part_in;
      out_word_ff  <= out_word_in;
      out_first_ff <= out_first_in;
      out_plast_ff <= out_plast_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_ts_word           = out_word_ff;
   assign rsp_packet_first_word = out_first_ff;
   assign rsp_packet_last_word  = out_plast_ff;
   assign rsp_last              = out_last_ff;

endmodule
`default_nettype wire

/* sv/ts_packetizer_core.sv */
// Transport stream packetizer top level. PES bytes enter one per req word and leave cut
// into 188-byte transport packets as 32-bit rsp words, earliest byte in bits 31:24. A
// byte that falls inside a packet's payload is taken straight from the idle state. A byte
// that opens a packet moves the back end into its header state, which emits each complete
// header word and, when the data byte does not finish a word, keeps the partial word for
// the payload bytes that follow; the single output word register, loaded at most once per
// cycle and held while rsp stalls, paces the header words. A two-entry queue between the byte
// classifier and the word builder lets input bytes keep arriving during a header burst.
// The per-stream continuity counters live in flip-flops and clear at reset.
`timescale 1ns / 1ps
`default_nettype none
`include "ts_packetizer_core_macros.svh"
module ts_packetizer_core #(
   parameter int unsigned STREAM_COUNT    = 8,
   parameter int unsigned PES_LENGTH_BITS = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_pes_start,
   input  wire logic [23:0] req_pes_length,
   input  wire logic        req_with_pcr,
   input  wire logic [32:0] req_pcr_base,
   input  wire logic [2:0]  req_stream_index,
   input  wire logic [12:0] req_pid,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_ts_word,
   output logic             rsp_packet_first_word,
   output logic             rsp_packet_last_word,
   output logic             rsp_last
);

   logic                   q_full;
   logic                   q_push;
   tsp_pkg::tsp_entry_type q_entry;
   logic                   q_pop;
   logic                   q_valid;
   tsp_pkg::tsp_entry_type q_head;

   tsp_front #(
      .STREAM_COUNT    (STREAM_COUNT),
      .PES_LENGTH_BITS (PES_LENGTH_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_pes_start    (req_pes_start),
      .req_pes_length   (req_pes_length),
      .req_with_pcr     (req_with_pcr),
      .req_pcr_base     (req_pcr_base),
      .req_stream_index (req_stream_index),
      .req_pid          (req_pid),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (q_entry)
   );

   tsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head       (q_head)
   );

   tsp_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head_valid            (q_valid),
      .head                  (q_head),
      .pop                   (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_ts_word           (rsp_ts_word),
      .rsp_packet_first_word (rsp_packet_first_word),
      .rsp_packet_last_word  (rsp_packet_last_word),
      .rsp_last              (rsp_last)
   );

   `TSP_ASSERT_IMPL(a_first_has_sync, rsp_valid && rsp_packet_first_word, rsp_ts_word[31:24] == tsp_pkg::SYNC_BYTE, "packet start word without sync byte")
   `TSP_ASSERT_IMPL(a_pkt_end_is_last, rsp_valid && rsp_packet_last_word, rsp_last, "packet end word not last of its byte")
   `TSP_ASSERT_IMPL(a_first_not_end, rsp_valid && rsp_packet_first_word, !rsp_packet_last_word, "word both starts and ends a packet")
   `TSP_ASSERT_NEXT(a_push_fills_queue, q_push, q_valid, "queue empty after a push")

endmodule
`default_nettype wire

/* bench/ts_packetizer_core_test.sv */
// Self-checking testbench for ts_packetizer_core: PES bytes in, transport packet words out.
`timescale 1ns / 1ps
module ts_packetizer_core_test;

   localparam int unsigned STREAMS       = 8;
   localparam int unsigned PKT_SIZE      = 188;
   localparam int unsigned ERR_PRINT_MAX = 40;

   // One input byte with its start fields; typed rows carry a hand-written expectation.
   typedef struct packed {
      logic [7:0]  data;
      logic        start;
      logic [23:0] len;
      logic        pcr;
      logic [32:0] base;
      logic [2:0]  strm;
      logic [12:0] pid;
      logic        typed;
      logic [7:0]  n_typed;
      logic [31:0] head_typed;
   } pes_byte_type;

   typedef struct packed {
      logic [31:0] word;
      logic        first_w;
      logic        last_pkt;
      logic        last_step;
   } ts_word_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_pes_start;
   logic [23:0] req_pes_length;
   logic        req_with_pcr;
   logic [32:0] req_pcr_base;
   logic [2:0]  req_stream_index;
   logic [12:0] req_pid;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_ts_word;
   logic        rsp_packet_first_word;
   logic        rsp_packet_last_word;
   logic        rsp_last;

   // Packetizer state as the bench sees it.
   logic [3:0]  cc_tab[STREAMS];
   logic [23:0] pes_left;
   int unsigned pkt_pos;
   logic [23:0] acc;
   int unsigned acc_n;
   logic [12:0] cur_pid;
   logic [2:0]  cur_stream;
   logic        first_pending;

   ts_word_type  words_due[$];
   ts_word_type  step_words[$];
   pes_byte_type dir_rows[$];

   int errs         = 0;
   int pes_opened   = 0;
   int bytes_fed    = 0;
   int strays       = 0;
   int words_seen   = 0;
   int packets_seen = 0;
   int req_quiet    = 0;
   int rsp_quiet    = 0;
   int rsp_hold     = 0;

   ts_packetizer_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_data_byte         (req_data_byte),
      .req_pes_start         (req_pes_start),
      .req_pes_length        (req_pes_length),
      .req_with_pcr          (req_with_pcr),
      .req_pcr_base          (req_pcr_base),
      .req_stream_index      (req_stream_index),
      .req_pid               (req_pid),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_ts_word           (rsp_ts_word),
      .rsp_packet_first_word (rsp_packet_first_word),
      .rsp_packet_last_word  (rsp_packet_last_word),
      .rsp_last              (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("ts_packetizer_core_test: done, errors");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (errs < ERR_PRINT_MAX)
         $display("ts_packetizer_core_test: %0t %s: got %h expected %h", $time, what, got, want);
      errs++;
   endtask

   // Mostly short gaps, now and then a long one, and quiet stretches with none.
   function automatic int idle_gap(inout int quiet);
      int r;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         quiet = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Append one stream byte; every fourth completes a word.
   function automatic void put_byte(input logic [7:0] b);
      ts_word_type w;
      logic        starts;
      starts = (pkt_pos == 3);
      pkt_pos++;
      if (acc_n == 3) begin
         w.word      = {acc, b};
         w.first_w   = starts;
         w.last_pkt  = (pkt_pos >= PKT_SIZE);
         w.last_step = 1'b0;
         step_words.push_back(w);
         acc   = '0;
         acc_n = 0;
      end else begin
         acc = {acc[15:0], b};
         acc_n++;
      end
      if (pkt_pos >= PKT_SIZE) pkt_pos = 0;
   endfunction

   function automatic void open_packet(input logic pcr_now, input logic [32:0] base);
      logic [7:0]  room;
      logic [7:0]  take;
      logic [7:0]  adapt;
      int unsigned at;
      room  = pcr_now ? tsp_pkg::PAYLOAD_PCR : tsp_pkg::PAYLOAD_FULL;
      take  = (pes_left < room) ? pes_left[7:0] : room;
      adapt = tsp_pkg::PAYLOAD_FULL - take;
      put_byte(tsp_pkg::SYNC_BYTE);
      put_byte({1'b0, first_pending, 1'b0, cur_pid[12:8]});
      put_byte(cur_pid[7:0]);
      put_byte({2'b00, adapt != 8'd0, 1'b1, cc_tab[cur_stream]});
      cc_tab[cur_stream] = cc_tab[cur_stream] + 4'd1;
      first_pending = 1'b0;
      if (adapt != 8'd0) begin
         put_byte(adapt - 8'd1);
         if (adapt > 8'd1) begin
            put_byte(pcr_now ? tsp_pkg::PCR_FLAG_BYTE : tsp_pkg::NO_FLAG_BYTE);
            at = 6;
            if (pcr_now) begin
               put_byte(base[32:25]);
               put_byte(base[24:17]);
               put_byte(base[16:9]);
               put_byte(base[8:1]);
               put_byte({base[0], tsp_pkg::PCR_EXT_FILL});
               put_byte(tsp_pkg::PCR_EXT_LOW);
               at += 6;
            end
            while (at < tsp_pkg::HDR_BYTES + adapt) begin
               put_byte(tsp_pkg::STUFF_BYTE);
               at++;
            end
         end
      end
   endfunction

   // Words caused by one accepted byte, left in step_words.
   function automatic void predict_words(input pes_byte_type it);
      logic        pcr_now;
      ts_word_type w;
      step_words.delete();
      pcr_now = 1'b0;
      if (pes_left == 0) begin
         // drop a byte that arrives with no PES open
         if (!it.start) begin
            strays++;
            return;
         end
         pes_left      = (it.len == 24'd0) ? 24'd1 : it.len;
         cur_stream    = it.strm;
         cur_pid       = it.pid;
         first_pending = 1'b1;
         pcr_now       = it.pcr;
         pkt_pos       = 0;
         acc           = '0;
         acc_n         = 0;
         pes_opened++;
      end
      if (pkt_pos == 0) open_packet(pcr_now, it.base);
      put_byte(it.data);
      pes_left--;
      if (step_words.size() > 0) begin
         w = step_words.pop_back();
         w.last_step = 1'b1;
         step_words.push_back(w);
      end
   endfunction

   task automatic send_byte(input pes_byte_type it);
      int          g;
      ts_word_type w;
      g = idle_gap(req_quiet);
      if (g > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (g - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_data_byte    <= it.data;
      req_pes_start    <= it.start;
      req_pes_length   <= it.len;
      req_with_pcr     <= it.pcr;
      req_pcr_base     <= it.base;
      req_stream_index <= it.strm;
      req_pid          <= it.pid;
      do @(posedge clock); while (req_stall);
      predict_words(it);
      if (it.typed) begin
         if (step_words.size() != it.n_typed)
            report_mismatch("word count of directed byte", step_words.size(),
                            32'(it.n_typed));
         if (step_words.size() > 0) begin
            w = step_words.pop_front();
            w.word = it.head_typed;
            step_words.push_front(w);
         end
      end
      foreach (step_words[i]) words_due.push_back(step_words[i]);
      bytes_fed++;
   endtask

   // Random byte with start low; its start fields are ignored by the block.
   function automatic pes_byte_type noise_byte();
      pes_byte_type it;
      logic [63:0]  r;
      r             = {$urandom(), $urandom()};
      it.data       = 8'($urandom_range(0, 255));
      it.start      = 1'b0;
      it.len        = 24'($urandom());
      it.pcr        = 1'($urandom_range(0, 1));
      it.base       = r[32:0];
      it.strm       = 3'($urandom_range(0, 7));
      it.pid        = 13'($urandom_range(0, 8191));
      it.typed      = 1'b0;
      it.n_typed    = '0;
      it.head_typed = '0;
      return it;
   endfunction

   // Mostly tiny PES, some right at the payload boundaries, a few spanning packets.
   function automatic logic [23:0] pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 24'($urandom_range(1, 4));
      if (r < 60) return 24'd0;
      if (r < 75) begin
         case ($urandom_range(0, 6))
            0:       return 24'(tsp_pkg::PAYLOAD_PCR - 8'd1);
            1:       return 24'(tsp_pkg::PAYLOAD_PCR);
            2:       return 24'(tsp_pkg::PAYLOAD_PCR + 8'd1);
            3:       return 24'(tsp_pkg::PAYLOAD_FULL - 8'd2);
            4:       return 24'(tsp_pkg::PAYLOAD_FULL - 8'd1);
            5:       return 24'(tsp_pkg::PAYLOAD_FULL);
            default: return 24'(tsp_pkg::PAYLOAD_FULL + 8'd1);
         endcase
      end
      if (r < 95) return 24'($urandom_range(5, 40));
      return 24'($urandom_range(2 * tsp_pkg::PAYLOAD_FULL - 8, 2 * tsp_pkg::PAYLOAD_FULL + 4));
   endfunction

   initial begin : rsp_side
      int g;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_hold--;
         end else begin
            g = idle_gap(rsp_quiet);
            rsp_stall <= (g > 0);
            rsp_hold = (g > 0) ? g - 1 : 0;
         end
      end
   end

   always @(posedge clock) begin : word_check
      ts_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_seen++;
         if (rsp_packet_last_word) packets_seen++;
         if (words_due.size() == 0) begin
            report_mismatch("word with nothing due", rsp_ts_word, 32'd0);
         end else begin
            want = words_due.pop_front();
            if (rsp_ts_word !== want.word)
               report_mismatch("ts_word", rsp_ts_word, want.word);
            if (rsp_packet_first_word !== want.first_w)
               report_mismatch("packet_first_word", 32'(rsp_packet_first_word),
                               32'(want.first_w));
            if (rsp_packet_last_word !== want.last_pkt)
               report_mismatch("packet_last_word", 32'(rsp_packet_last_word),
                               32'(want.last_pkt));
            if (rsp_last !== want.last_step)
               report_mismatch("last", 32'(rsp_last), 32'(want.last_step));
         end
      end
   end

   initial begin : stimulus
      pes_byte_type it;
      int           rand_bytes;
      int           k;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = '0;
      req_pes_start    = 1'b0;
      req_pes_length   = '0;
      req_with_pcr     = 1'b0;
      req_pcr_base     = '0;
      req_stream_index = '0;
      req_pid          = '0;
      foreach (cc_tab[i]) cc_tab[i] = 4'd0;
      pes_left      = '0;
      pkt_pos       = 0;
      acc           = '0;
      acc_n         = 0;
      cur_pid       = '0;
      cur_stream    = '0;
      first_pending = 1'b0;
      rand_bytes    = 0;

      // data, start, length, pcr, base, stream, pid, typed, words, first word
      dir_rows.push_back('{8'hFF, 1'b1, 24'd1, 1'b0, 33'd0, 3'd7, 13'h1FFF,
                           1'b1, 8'd47, 32'h475FFF30});
      dir_rows.push_back('{8'h00, 1'b0, 24'hFFFFFF, 1'b1, 33'h1_FFFF_FFFF, 3'd7, 13'h1FFF,
                           1'b1, 8'd0, 32'h0});
      dir_rows.push_back('{8'h00, 1'b1, 24'd0, 1'b1, 33'd0, 3'd0, 13'h0000,
                           1'b1, 8'd47, 32'h47400030});
      dir_rows.push_back('{8'h5A, 1'b1, 24'd1, 1'b1, 33'h1_FFFF_FFFF, 3'd0, 13'h0100,
                           1'b1, 8'd47, 32'h47410031});
      dir_rows.push_back('{8'h11, 1'b1, 24'd3, 1'b1, 33'h0_1234_5678, 3'd7, 13'h00AA,
                           1'b0, 8'd0, 32'h0});
      // start during an open PES is plain payload
      dir_rows.push_back('{8'h22, 1'b1, 24'h800000, 1'b0, 33'h1_0000_0000, 3'd2, 13'h1555,
                           1'b0, 8'd0, 32'h0});
      dir_rows.push_back('{8'h33, 1'b0, 24'd0, 1'b0, 33'd0, 3'd0, 13'h0000,
                           1'b0, 8'd0, 32'h0});
      dir_rows.push_back('{8'h80, 1'b1, 24'd2, 1'b0, 33'h0_AAAA_AAAA, 3'd3, 13'h1000,
                           1'b0, 8'd0, 32'h0});
      dir_rows.push_back('{8'h7F, 1'b1, 24'h7FFFFF, 1'b1, 33'h0_5555_5555, 3'd4, 13'h0FFF,
                           1'b0, 8'd0, 32'h0});
      dir_rows.push_back('{8'h01, 1'b0, 24'd0, 1'b0, 33'd0, 3'd0, 13'h0000,
                           1'b1, 8'd0, 32'h0});
      dir_rows.push_back('{8'hC3, 1'b1, 24'd4, 1'b0, 33'h0_0F0F_0F0F, 3'd1, 13'h0001,
                           1'b0, 8'd0, 32'h0});
      dir_rows.push_back('{8'h3C, 1'b0, 24'd0, 1'b0, 33'd0, 3'd6, 13'h0000,
                           1'b0, 8'd0, 32'h0});
      dir_rows.push_back('{8'hE7, 1'b1, 24'd9, 1'b1, 33'd1, 3'd5, 13'h0AAA,
                           1'b0, 8'd0, 32'h0});
      dir_rows.push_back('{8'h18, 1'b0, 24'd0, 1'b0, 33'd0, 3'd0, 13'h0000,
                           1'b0, 8'd0, 32'h0});

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_byte(dir_rows[i]);

      // well-formed PES with random content, salted with stray bytes and mid-PES starts
      while (rand_bytes < 250) begin
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 2)) send_byte(noise_byte());
         it       = noise_byte();
         it.start = 1'b1;
         it.len   = pick_len();
         if ($urandom_range(0, 1)) it.strm = 3'd5;
         send_byte(it);
         rand_bytes++;
         for (k = 1; k < it.len; k++) begin
            it       = noise_byte();
            it.start = ($urandom_range(0, 19) == 0);
            send_byte(it);
            rand_bytes++;
         end
      end

      // leave one huge PES open at the end of the run
      it       = noise_byte();
      it.start = 1'b1;
      it.pcr   = 1'b1;
      it.len   = {1'b1, it.len[22:0]};
      send_byte(it);
      repeat (40) send_byte(noise_byte());

      @(negedge clock);
      req_valid <= 1'b0;

      for (k = 0; k < 200000 && words_due.size() != 0; k++) @(posedge clock);
      repeat (100) @(posedge clock);
      if (words_due.size() != 0)
         report_mismatch("words never delivered", 32'd0, words_due.size());

      $display("ts_packetizer_core_test: %0d PES opened from %0d bytes (%0d stray)",
               pes_opened, bytes_fed, strays);
      $display("ts_packetizer_core_test: %0d words in %0d packets checked, %0d mismatches",
               words_seen, packets_seen, errs);
      if (errs == 0) begin
         $display("ts_packetizer_core_test: done, clean");
      end else begin
         $display("ts_packetizer_core_test: done, errors");
      end
      $finish;
   end

endmodule
